FILE: sv/cma_pkg.sv
// Shared types and constants of the confusion-matrix accumulator.
`default_nettype none

package cma_pkg;

    localparam int SCORE_INPUTS = 8;   // score fields per item
    localparam int LABEL_BITS   = 3;   // label, prediction, row and column fields
    localparam int CFG_BITS     = 4;   // classes-in-use register
    localparam int MIN_CLASSES  = 2;

    typedef enum logic {
        ACT_RECORD = 1'b0,
        ACT_READ   = 1'b1
    } action_t;

    // Per-class counter bumps issued by the update stage
    typedef struct packed {
        logic tp;
        logic fp;
        logic fn;
    } cnt_bump_t;

endpackage

`default_nettype wire

FILE: sv/cma_in_if.sv
// Input channel: record or read items.
`default_nettype none

interface cma_in_if #(
    parameter int SCORE_BITS = 16
);
    import cma_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [LABEL_BITS-1:0]        true_label;
    logic signed [SCORE_BITS-1:0] score_0;
    logic signed [SCORE_BITS-1:0] score_1;
    logic signed [SCORE_BITS-1:0] score_2;
    logic signed [SCORE_BITS-1:0] score_3;
    logic signed [SCORE_BITS-1:0] score_4;
    logic signed [SCORE_BITS-1:0] score_5;
    logic signed [SCORE_BITS-1:0] score_6;
    logic signed [SCORE_BITS-1:0] score_7;
    logic [LABEL_BITS-1:0]        read_row;
    logic [LABEL_BITS-1:0]        read_col;

    modport source (
        output valid, action, true_label,
               score_0, score_1, score_2, score_3, score_4, score_5, score_6, score_7,
               read_row, read_col,
        input  ready
    );

    modport sink (
        input  valid, action, true_label,
               score_0, score_1, score_2, score_3, score_4, score_5, score_6, score_7,
               read_row, read_col,
        output ready
    );

endinterface

`default_nettype wire

FILE: sv/cma_out_if.sv
// Output channel: one result item per input item.
`default_nettype none

interface cma_out_if #(
    parameter int COUNT_BITS = 32
);
    import cma_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LABEL_BITS-1:0] predicted_class;
    logic                  is_correct;
    logic                  label_error;
    logic [COUNT_BITS-1:0] true_pos_count;
    logic [COUNT_BITS-1:0] false_pos_count;
    logic [COUNT_BITS-1:0] false_neg_count;
    logic [COUNT_BITS-1:0] cell_count;

    modport source (
        output valid, predicted_class, is_correct, label_error,
               true_pos_count, false_pos_count, false_neg_count, cell_count,
        input  ready
    );

    modport sink (
        input  valid, predicted_class, is_correct, label_error,
               true_pos_count, false_pos_count, false_neg_count, cell_count,
        output ready
    );

endinterface

`default_nettype wire

FILE: sv/cma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/cma_argmax.sv
// Argmax over the active score lanes, lowest index wins on ties.
`default_nettype none

module cma_argmax #(
    parameter int SCORE_BITS = 16
) (
    input  wire logic signed [SCORE_BITS-1:0]            score [cma_pkg::SCORE_INPUTS],
    input  wire logic        [cma_pkg::CFG_BITS-1:0]     active_n,
    output logic             [cma_pkg::LABEL_BITS-1:0]   best
);
    import cma_pkg::*;

    logic [SCORE_INPUTS-1:0]       ok0;
    logic [3:0]                    ok1;
    logic [1:0]                    ok2;
    logic signed [SCORE_BITS-1:0]  v1 [4];
    logic signed [SCORE_BITS-1:0]  v2 [2];
    logic [LABEL_BITS-1:0]         i1 [4];
    logic [LABEL_BITS-1:0]         i2 [2];

    // Three-level compare tree; the right side wins only when active and strictly greater.
    always_comb
    begin
        for (int i = 0; i < SCORE_INPUTS; i++)
        begin
            ok0[i] = {1'b0, LABEL_BITS'(i)} < active_n;
        end

        for (int j = 0; j < 4; j++)
        begin
            if (ok0[2*j+1] && (!ok0[2*j] || score[2*j+1] > score[2*j]))
            begin
                v1[j] = score[2*j+1];
                i1[j] = LABEL_BITS'(2*j+1);
            end
            else
            begin
                v1[j] = score[2*j];
                i1[j] = LABEL_BITS'(2*j);
            end
            ok1[j] = ok0[2*j] | ok0[2*j+1];
        end

        for (int j = 0; j < 2; j++)
        begin
            if (ok1[2*j+1] && (!ok1[2*j] || v1[2*j+1] > v1[2*j]))
            begin
                v2[j] = v1[2*j+1];
                i2[j] = i1[2*j+1];
            end
            else
            begin
                v2[j] = v1[2*j];
                i2[j] = i1[2*j];
            end
            ok2[j] = ok1[2*j] | ok1[2*j+1];
        end

        if (ok2[1] && (!ok2[0] || v2[1] > v2[0]))
        begin
            best = i2[1];
        end
        else
        begin
            best = i2[0];
        end
    end

endmodule

`default_nettype wire

FILE: sv/cma_class_counters.sv
// Per-class tp/fp/fn saturating counters; tp and fn share a read index, fp has its own.
`default_nettype none

module cma_class_counters #(
    parameter int MAX_CLASSES = 8,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cma_pkg::cnt_bump_t             bump,
    input  wire logic [$clog2(MAX_CLASSES)-1:0] tf_idx,
    input  wire logic [$clog2(MAX_CLASSES)-1:0] fp_idx,
    output logic      [COUNT_BITS-1:0]          tp_rd,
    output logic      [COUNT_BITS-1:0]          fp_rd,
    output logic      [COUNT_BITS-1:0]          fn_rd
);
    import cma_pkg::*;

    logic [COUNT_BITS-1:0] tp_reg [MAX_CLASSES];
    logic [COUNT_BITS-1:0] fp_reg [MAX_CLASSES];
    logic [COUNT_BITS-1:0] fn_reg [MAX_CLASSES];
    logic [COUNT_BITS-1:0] tp_next;
    logic [COUNT_BITS-1:0] fp_next;
    logic [COUNT_BITS-1:0] fn_next;

    // tp and fn share the label index; fp follows the prediction
    assign tp_rd = tp_reg[tf_idx];
    assign fn_rd = fn_reg[tf_idx];
    assign fp_rd = fp_reg[fp_idx];

    // saturate at all ones
    assign tp_next = (&tp_rd) ? tp_rd : tp_rd + COUNT_BITS'(1);
    assign fp_next = (&fp_rd) ? fp_rd : fp_rd + COUNT_BITS'(1);
    assign fn_next = (&fn_rd) ? fn_rd : fn_rd + COUNT_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                tp_reg[i] <= '0;
                fp_reg[i] <= '0;
                fn_reg[i] <= '0;
            end
        end
        else
        begin
            if (bump.tp)
            begin
                tp_reg[tf_idx] <= tp_next;
            end
            if (bump.fn)
            begin
                fn_reg[tf_idx] <= fn_next;
            end
            if (bump.fp)
            begin
                fp_reg[fp_idx] <= fp_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/confusion_matrix_accumulator.sv
// Top level of the multiclass confusion-matrix accumulator.
// Pipeline: input (A), update (B) and result (O) registers; one item per cycle while the
//   result side takes items. The matrix RAM read-modify-write spans the input and update
//   stages, with a bypass of the write made at the edge the read was taken.
// Reset: asynchronous, clears all counters (matrix entries through per-entry valid bits),
//   empties the pipeline and sets classes-in-use to its maximum; no clearing pass.
`default_nettype none

module confusion_matrix_accumulator #(
    parameter int MAX_CLASSES = 8,
    parameter int COUNT_BITS  = 32,
    parameter int SCORE_BITS  = 16   // must match the width of the sample interface
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [cma_pkg::CFG_BITS-1:0] cfg_wr_data,
    cma_in_if.sink                            sample,
    cma_out_if.source                         result
);
    import cma_pkg::*;

    localparam int CW         = $clog2(MAX_CLASSES);   // class index bits
    localparam int AW         = 2 * CW;                // matrix address {row, col}
    localparam int CELL_DEPTH = 1 << AW;
    // argmax and counting never go past the score lanes
    localparam int CLASS_LIM  = (MAX_CLASSES < SCORE_INPUTS) ? MAX_CLASSES : SCORE_INPUTS;
    localparam logic [CFG_BITS-1:0] LIM_CODE = CFG_BITS'(CLASS_LIM);
    localparam logic [CFG_BITS-1:0] MIN_CODE = CFG_BITS'(MIN_CLASSES);
    // rows / columns below this exist in the store
    localparam int ROW_LIM = (MAX_CLASSES < (1 << LABEL_BITS)) ? MAX_CLASSES : (1 << LABEL_BITS);
    localparam logic [LABEL_BITS:0] ROW_LIM_CODE = (LABEL_BITS + 1)'(ROW_LIM);

    // ---------------- configuration ----------------
    // Stored already clamped to [2, CLASS_LIM]; reset sets CLASS_LIM.
    logic [CFG_BITS-1:0] active_n_reg;
    logic [CFG_BITS-1:0] active_n_next;

    always_comb
    begin
        if (cfg_wr_data < MIN_CODE)
        begin
            active_n_next = MIN_CODE;
        end
        else if (cfg_wr_data > LIM_CODE)
        begin
            active_n_next = LIM_CODE;
        end
        else
        begin
            active_n_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_n_reg <= LIM_CODE;
        end
        else if (cfg_wr_en)
        begin
            active_n_reg <= active_n_next;
        end
    end

    // ---------------- handshake ----------------
    // Three registered stages: input (A), update (B), result (O).
    logic a_valid_reg;
    logic b_valid_reg;
    logic o_valid_reg;
    logic o_load;
    logic b_ready;
    logic a_advance;
    logic in_fire;

    assign o_load    = b_valid_reg && (!o_valid_reg || result.ready);
    assign b_ready   = !b_valid_reg || o_load;
    assign a_advance = a_valid_reg && b_ready;
    assign sample.ready = !a_valid_reg || b_ready;
    assign in_fire   = sample.valid && sample.ready;

    // ---------------- stage A: input register ----------------
    action_t                      a_action_reg;
    logic [LABEL_BITS-1:0]        a_label_reg;
    logic [LABEL_BITS-1:0]        a_row_reg;
    logic [LABEL_BITS-1:0]        a_col_reg;
    logic signed [SCORE_BITS-1:0] a_score_reg [SCORE_INPUTS];
    logic signed [SCORE_BITS-1:0] in_score    [SCORE_INPUTS];

    assign in_score[0] = sample.score_0;
    assign in_score[1] = sample.score_1;
    assign in_score[2] = sample.score_2;
    assign in_score[3] = sample.score_3;
    assign in_score[4] = sample.score_4;
    assign in_score[5] = sample.score_5;
    assign in_score[6] = sample.score_6;
    assign in_score[7] = sample.score_7;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            a_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_action_reg <= action_t'(sample.action);
            a_label_reg  <= sample.true_label;
            a_row_reg    <= sample.read_row;
            a_col_reg    <= sample.read_col;
            for (int i = 0; i < SCORE_INPUTS; i++)
            begin
                a_score_reg[i] <= in_score[i];
            end
        end
    end

    // Stage A logic: argmax, range checks, matrix address for the RAM read.
    logic [LABEL_BITS-1:0] a_best;
    logic                  a_label_err;
    logic                  a_row_ok;
    logic                  a_col_ok;
    logic [AW-1:0]         a_addr;
    logic [CW-1:0]         a_tf_idx;
    logic [CW-1:0]         a_fp_idx;

    cma_argmax #(
        .SCORE_BITS (SCORE_BITS)
    ) u_argmax (
        .score    (a_score_reg),
        .active_n (active_n_reg),
        .best     (a_best)
    );

    assign a_label_err = {1'b0, a_label_reg} >= active_n_reg;
    assign a_row_ok    = {1'b0, a_row_reg} < ROW_LIM_CODE;
    assign a_col_ok    = {1'b0, a_col_reg} < ROW_LIM_CODE;

    // A read item reuses the label-side and prediction-side paths with its row.
    always_comb
    begin
        if (a_action_reg == ACT_READ)
        begin
            a_tf_idx = CW'(a_row_reg);
            a_fp_idx = CW'(a_row_reg);
            a_addr   = {CW'(a_row_reg), CW'(a_col_reg)};
        end
        else
        begin
            a_tf_idx = CW'(a_label_reg);
            a_fp_idx = CW'(a_best);
            a_addr   = {CW'(a_label_reg), CW'(a_best)};
        end
    end

    // ---------------- stage B: update ----------------
    action_t               b_action_reg;
    logic [LABEL_BITS-1:0] b_best_reg;
    logic                  b_correct_reg;
    logic                  b_label_err_reg;
    logic                  b_row_ok_reg;
    logic                  b_cell_ok_reg;
    logic [CW-1:0]         b_tf_idx_reg;
    logic [CW-1:0]         b_fp_idx_reg;
    logic [AW-1:0]         b_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_advance)
        begin
            b_action_reg    <= a_action_reg;
            b_best_reg      <= a_best;
            b_correct_reg   <= !a_label_err && (a_label_reg == a_best);
            b_label_err_reg <= a_label_err;
            b_row_ok_reg    <= a_row_ok;
            // record: counted only with a good label; read: both indexes in the store
            b_cell_ok_reg   <= (a_action_reg == ACT_READ) ? (a_row_ok && a_col_ok) : !a_label_err;
            b_tf_idx_reg    <= a_tf_idx;
            b_fp_idx_reg    <= a_fp_idx;
            b_addr_reg      <= a_addr;
        end
    end

    // Matrix store: RAM plus one valid bit per entry so reset reads as zero.
    logic [COUNT_BITS-1:0] cell_rd;
    logic [COUNT_BITS-1:0] cell_old;
    logic [COUNT_BITS-1:0] cell_new;
    logic                  cell_wr_en;
    logic [CELL_DEPTH-1:0] cell_vld_reg;
    logic                  fwd_valid_reg;
    logic [AW-1:0]         fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic                  b_record_ok;

    assign b_record_ok = (b_action_reg == ACT_RECORD) && b_cell_ok_reg;
    assign cell_wr_en  = o_load && b_record_ok;

    cma_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CELL_DEPTH)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (cell_wr_en),
        .wr_addr (b_addr_reg),
        .wr_data (cell_new),
        .rd_en   (a_advance),
        .rd_addr (a_addr),
        .rd_data (cell_rd)
    );

    // The RAM read misses a write made at the same edge; take that value from the bypass.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == b_addr_reg))
        begin
            cell_old = fwd_data_reg;
        end
        else if (cell_vld_reg[b_addr_reg])
        begin
            cell_old = cell_rd;
        end
        else
        begin
            cell_old = '0;
        end
    end

    assign cell_new = (&cell_old) ? cell_old : cell_old + COUNT_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_vld_reg  <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cell_wr_en)
            begin
                cell_vld_reg[b_addr_reg] <= 1'b1;
            end
            // bypass tracks the write seen (or not) by the item entering stage B
            if (a_advance)
            begin
                fwd_valid_reg <= cell_wr_en;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_advance)
        begin
            fwd_addr_reg <= b_addr_reg;
            fwd_data_reg <= cell_new;
        end
    end

    // Per-class counters
    cnt_bump_t             bump;
    logic [COUNT_BITS-1:0] tp_rd;
    logic [COUNT_BITS-1:0] fp_rd;
    logic [COUNT_BITS-1:0] fn_rd;

    assign bump.tp = o_load && b_record_ok && b_correct_reg;
    assign bump.fn = o_load && b_record_ok && !b_correct_reg;
    assign bump.fp = o_load && b_record_ok && !b_correct_reg;

    cma_class_counters #(
        .MAX_CLASSES (MAX_CLASSES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_counters (
        .clk    (clk),
        .rst_n  (rst_n),
        .bump   (bump),
        .tf_idx (b_tf_idx_reg),
        .fp_idx (b_fp_idx_reg),
        .tp_rd  (tp_rd),
        .fp_rd  (fp_rd),
        .fn_rd  (fn_rd)
    );

    // ---------------- stage O: result register ----------------
    logic [LABEL_BITS-1:0] o_pred_reg;
    logic                  o_correct_reg;
    logic                  o_lerr_reg;
    logic [COUNT_BITS-1:0] o_tp_reg;
    logic [COUNT_BITS-1:0] o_fp_reg;
    logic [COUNT_BITS-1:0] o_fn_reg;
    logic [COUNT_BITS-1:0] o_cell_reg;
    logic                  b_is_read;

    assign b_is_read = (b_action_reg == ACT_READ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (!o_valid_reg || result.ready)
        begin
            o_valid_reg <= b_valid_reg;
        end
    end

    // Record items report the prediction; read items report the counters.
    always_ff @(posedge clk)
    begin
        if (o_load)
        begin
            o_pred_reg    <= b_is_read ? '0 : b_best_reg;
            o_correct_reg <= !b_is_read && b_correct_reg;
            o_lerr_reg    <= !b_is_read && b_label_err_reg;
            o_tp_reg      <= (b_is_read && b_row_ok_reg) ? tp_rd : '0;
            o_fp_reg      <= (b_is_read && b_row_ok_reg) ? fp_rd : '0;
            o_fn_reg      <= (b_is_read && b_row_ok_reg) ? fn_rd : '0;
            o_cell_reg    <= (b_is_read && b_cell_ok_reg) ? cell_old : '0;
        end
    end

    assign result.valid           = o_valid_reg;
    assign result.predicted_class = o_pred_reg;
    assign result.is_correct      = o_correct_reg;
    assign result.label_error     = o_lerr_reg;
    assign result.true_pos_count  = o_tp_reg;
    assign result.false_pos_count = o_fp_reg;
    assign result.false_neg_count = o_fn_reg;
    assign result.cell_count      = o_cell_reg;

`ifndef SYNTHESIS
    // A flagged label is never reported as correct and carries no counts.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.label_error |-> !result.is_correct && result.cell_count == '0)
        else $error("label error with correct flag or counts");

    // A matrix write marks its entry valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_wr_en |=> cell_vld_reg[$past(b_addr_reg)])
        else $error("matrix entry not marked valid after write");

    // Stage A holds its item while stage B cannot take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !b_ready |=> a_valid_reg)
        else $error("stage A item dropped under stall");

    // An accepted item lands in stage A.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> a_valid_reg)
        else $error("accepted item not captured");

    // Counters change only when a record item leaves the update stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (bump.tp || bump.fp || cell_wr_en) |-> o_load && !b_is_read)
        else $error("counter update outside a record item");
`endif

endmodule

`default_nettype wire

FILE: tb/confusion_checker.sv
// Checker for the confusion-matrix accumulator: mirrors its counters and compares every result item.
`timescale 1ns / 100ps

module confusion_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [cma_pkg::CFG_BITS-1:0] cfg_wr_data,
    cma_in_if                            sample,
    cma_out_if                           result,
    output int                           fail_count,
    output int                           outstanding,
    output int                           record_count,
    output int                           flagged_count,
    output int                           read_count
);
    import cma_pkg::*;

    localparam int CLASSES   = 8;
    localparam int PRINT_CAP = 60;

    typedef logic [31:0]        count_t;
    typedef logic signed [15:0] score_t;

    typedef struct packed {
        logic [LABEL_BITS-1:0] predicted_class;
        logic                  is_correct;
        logic                  label_error;
        count_t                tp;
        count_t                fp;
        count_t                fn;
        count_t                entry;
    } outcome_t;

    // Mirror of the block's store and register
    count_t              cell_tally [CLASSES][CLASSES];
    count_t              tp_tally   [CLASSES];
    count_t              fp_tally   [CLASSES];
    count_t              fn_tally   [CLASSES];
    logic [CFG_BITS-1:0] classes_reg;
    outcome_t            outcome_q [$];

    function automatic count_t sat_inc(input count_t c);
        return (c == '1) ? c : c + count_t'(1);
    endfunction

    // Register codes below the minimum act as two, above the class count as eight
    function automatic int active_classes(input logic [CFG_BITS-1:0] raw);
        if (raw < MIN_CLASSES)
            return MIN_CLASSES;
        if (raw > CLASSES)
            return CLASSES;
        return int'(raw);
    endfunction

    // Works out one result item and applies the counter updates of a record
    function automatic outcome_t predict_outcome(
        input action_t               act,
        input logic [LABEL_BITS-1:0] label,
        input score_t                sc [CLASSES],
        input logic [LABEL_BITS-1:0] row,
        input logic [LABEL_BITS-1:0] col
    );
        outcome_t o;
        int       n;
        int       best;
        o = '0;
        if (act == ACT_RECORD) begin
            n    = active_classes(classes_reg);
            best = 0;
            // strict compare keeps the lowest index on a tie
            for (int k = 1; k < n; k++)
                if (sc[k] > sc[best])
                    best = k;
            o.predicted_class = best[LABEL_BITS-1:0];
            if (label >= n)
                o.label_error = 1'b1;
            else begin
                cell_tally[label][best] = sat_inc(cell_tally[label][best]);
                if (label == best) begin
                    o.is_correct    = 1'b1;
                    tp_tally[label] = sat_inc(tp_tally[label]);
                end
                else begin
                    fn_tally[label] = sat_inc(fn_tally[label]);
                    fp_tally[best]  = sat_inc(fp_tally[best]);
                end
            end
        end
        else begin
            o.tp    = tp_tally[row];
            o.fp    = fp_tally[row];
            o.fn    = fn_tally[row];
            o.entry = cell_tally[row][col];
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input count_t want, input count_t got);
        if (fail_count < PRINT_CAP)
            $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        fail_count++;
    endtask

    task automatic check_field(input string what, input count_t want, input count_t got);
        if (got !== want)
            report_mismatch(what, want, got);
    endtask

    always @(posedge clk or negedge rst_n) begin
        outcome_t want;
        outcome_t got;
        score_t   sc [CLASSES];
        if (!rst_n) begin
            classes_reg = CFG_BITS'(CLASSES);
            for (int r = 0; r < CLASSES; r++) begin
                tp_tally[r] = '0;
                fp_tally[r] = '0;
                fn_tally[r] = '0;
                for (int c = 0; c < CLASSES; c++)
                    cell_tally[r][c] = '0;
            end
            outcome_q.delete();
            fail_count    = 0;
            record_count  = 0;
            flagged_count = 0;
            read_count    = 0;
            outstanding <= 0;
        end
        else begin
            // results first: an item accepted at this edge cannot have its result yet
            if (result.valid && result.ready) begin
                if (outcome_q.size() == 0)
                    report_mismatch("result item with nothing expected", '0,
                                    count_t'(result.predicted_class));
                else begin
                    want = outcome_q.pop_front();
                    check_field("predicted_class", count_t'(want.predicted_class),
                                count_t'(result.predicted_class));
                    check_field("is_correct", count_t'(want.is_correct),
                                count_t'(result.is_correct));
                    check_field("label_error", count_t'(want.label_error),
                                count_t'(result.label_error));
                    check_field("true_pos_count", want.tp, result.true_pos_count);
                    check_field("false_pos_count", want.fp, result.false_pos_count);
                    check_field("false_neg_count", want.fn, result.false_neg_count);
                    check_field("cell_count", want.entry, result.cell_count);
                end
            end
            if (sample.valid && sample.ready) begin
                sc[0] = sample.score_0;
                sc[1] = sample.score_1;
                sc[2] = sample.score_2;
                sc[3] = sample.score_3;
                sc[4] = sample.score_4;
                sc[5] = sample.score_5;
                sc[6] = sample.score_6;
                sc[7] = sample.score_7;
                got = predict_outcome(action_t'(sample.action), sample.true_label, sc,
                                      sample.read_row, sample.read_col);
                outcome_q = {outcome_q, got};
                if (sample.action == ACT_READ)
                    read_count++;
                else begin
                    record_count++;
                    if (got.label_error)
                        flagged_count++;
                end
            end
            if (cfg_wr_en)
                classes_reg = cfg_wr_data;
            outstanding <= outcome_q.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Testbench top for the confusion-matrix accumulator: stimulus, idling, watchdog and verdict.
`timescale 1ns / 100ps

module tb;
    import cma_pkg::*;

    localparam int CLASSES         = 8;
    localparam int ITEMS_PER_PHASE = 126;
    localparam int DIRECTED_ITEMS  = 16;
    localparam int QUIET_LIMIT     = 5000;   // cycles without any handshake before giving up

    // Register codes visited after the directed part; 0, 1, 9, 12 and 15 exercise the clamping,
    // 2 and 8 are the real extremes.
    localparam logic [CFG_BITS-1:0] CFG_PLAN [13] = '{
        4'd2, 4'd8, 4'd0, 4'd15, 4'd5, 4'd3, 4'd1, 4'd9, 4'd7, 4'd4, 4'd6, 4'd12, 4'd8
    };
    localparam int TOTAL_ITEMS = DIRECTED_ITEMS + 13 * ITEMS_PER_PHASE;

    typedef logic signed [15:0] score_t;

    typedef struct {
        action_t               act;
        logic [LABEL_BITS-1:0] label;
        score_t                sc [CLASSES];
        logic [LABEL_BITS-1:0] row;
        logic [LABEL_BITS-1:0] col;
    } sample_item_t;

    logic                clk   = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en;
    logic [CFG_BITS-1:0] cfg_wr_data;
    logic [CFG_BITS-1:0] cfg_now;

    int tx_idle_pct  = 34;
    int rx_idle_pct  = 73;
    int sent_count   = 0;
    int quiet_cycles = 0;
    int fail_count;
    int outstanding;
    int record_count;
    int flagged_count;
    int read_count;

    cma_in_if  #(.SCORE_BITS(16)) sample_ch ();
    cma_out_if #(.COUNT_BITS(32)) result_ch ();

    confusion_matrix_accumulator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (sample_ch.sink),
        .result      (result_ch.source)
    );

    confusion_checker matrix_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .sample        (sample_ch),
        .result        (result_ch),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .record_count  (record_count),
        .flagged_count (flagged_count),
        .read_count    (read_count)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: back-pressure at the rate of the current idling stage
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            result_ch.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: a run that stops moving is a failure
    always @(posedge clk) begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: %0d cycles without a handshake, %0d results pending",
                     quiet_cycles, outstanding);
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one item and holds it until the block takes it. The idling mix follows the
    // position in the run: receiver-heavy gaps first, sender-heavy next, then full rate.
    task automatic push_item(input sample_item_t it);
        if (sent_count < TOTAL_ITEMS / 3) begin
            tx_idle_pct = 34;
            rx_idle_pct = 73;
        end
        else if (sent_count < 2 * TOTAL_ITEMS / 3) begin
            tx_idle_pct = 73;
            rx_idle_pct = 34;
        end
        else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.action     <= it.act;
        sample_ch.true_label <= it.label;
        sample_ch.score_0    <= it.sc[0];
        sample_ch.score_1    <= it.sc[1];
        sample_ch.score_2    <= it.sc[2];
        sample_ch.score_3    <= it.sc[3];
        sample_ch.score_4    <= it.sc[4];
        sample_ch.score_5    <= it.sc[5];
        sample_ch.score_6    <= it.sc[6];
        sample_ch.score_7    <= it.sc[7];
        sample_ch.read_row   <= it.row;
        sample_ch.read_col   <= it.col;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        sent_count++;
    endtask

    task automatic send_record(input int label, input score_t s [CLASSES]);
        sample_item_t it;
        it.act   = ACT_RECORD;
        it.label = LABEL_BITS'(label);
        it.sc    = s;
        it.row   = '0;
        it.col   = '0;
        push_item(it);
    endtask

    // Label and score fields carry junk on reads; the block must ignore them
    task automatic send_read(input int row, input int col);
        sample_item_t it;
        it.act   = ACT_READ;
        it.label = LABEL_BITS'($urandom_range(7));
        foreach (it.sc[k])
            it.sc[k] = score_t'($urandom);
        it.row   = LABEL_BITS'(row);
        it.col   = LABEL_BITS'(col);
        push_item(it);
    endtask

    // Sender stops, then waits until every expected result item has come back.
    // The first edge lets the checker's count catch up with the last accepted item.
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_classes(input logic [CFG_BITS-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_now      = v;
    endtask

    // Mostly records; labels mostly inside the active classes, some anywhere so that
    // the label check fires. Score shapes: fully random, a narrow band that produces
    // ties, a planted winner over random scores (often the label, to get true
    // positives), and rails only.
    function automatic sample_item_t random_item(input int n);
        sample_item_t it;
        int           shape;
        int           winner;
        it.act   = ($urandom_range(99) < 25) ? ACT_READ : ACT_RECORD;
        it.label = ($urandom_range(99) < 25) ? LABEL_BITS'($urandom_range(7))
                                             : LABEL_BITS'($urandom_range(n - 1));
        it.row   = LABEL_BITS'($urandom_range(7));
        it.col   = LABEL_BITS'($urandom_range(7));
        shape    = $urandom_range(99);
        winner   = ($urandom_range(99) < 60) ? int'(it.label) : $urandom_range(7);
        foreach (it.sc[k]) begin
            it.sc[k] = score_t'($urandom);
            if (shape >= 45 && shape < 70)
                it.sc[k] = score_t'(int'($urandom_range(4)) - 2);
            if (shape >= 90)
                it.sc[k] = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        end
        if (shape >= 70 && shape < 90)
            it.sc[winner] = 16'sh7FFF - score_t'($urandom_range(2));
        return it;
    endfunction

    initial begin
        int n;
        sample_ch.valid      <= 1'b0;
        sample_ch.action     <= ACT_RECORD;
        sample_ch.true_label <= '0;
        sample_ch.score_0    <= '0;
        sample_ch.score_1    <= '0;
        sample_ch.score_2    <= '0;
        sample_ch.score_3    <= '0;
        sample_ch.score_4    <= '0;
        sample_ch.score_5    <= '0;
        sample_ch.score_6    <= '0;
        sample_ch.score_7    <= '0;
        sample_ch.read_row   <= '0;
        sample_ch.read_col   <= '0;
        cfg_wr_en            <= 1'b0;
        cfg_wr_data          <= '0;
        cfg_now               = CFG_BITS'(CLASSES);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset setting of eight classes
        send_read(0, 0);                                   // empty store reads zero
        // all equal: tie resolves to class 0, label 0 -> hit
        send_record(0, '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                         16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
        // all at the negative rail: class 0 wins, label 7 -> miss
        send_record(7, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                         16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        // top class alone at the positive rail
        send_record(7, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                         16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF});
        // tie between 3 and 5 goes to 3: once a hit, once a miss
        send_record(3, '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF,
                         16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh0000});
        send_record(5, '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF,
                         16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh0000});
        // signed order: -1 beats -2
        send_record(1, '{16'shFFFF, 16'shFFFE, 16'sh8000, 16'sh8000,
                         16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        // +1 beats -1 although -1 is larger unsigned
        send_record(2, '{16'shFFFF, 16'shFFFF, 16'sh0001, 16'shFFFF,
                         16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF});
        // one step above the negative rail wins
        send_record(6, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                         16'sh8000, 16'sh8000, 16'sh8001, 16'sh8000});
        send_read(7, 0);
        send_read(0, 7);
        send_read(7, 7);
        send_read(3, 3);
        send_read(5, 3);
        send_read(3, 5);
        send_read(0, 0);

        // Random phases, one per register setting, each entered with the block drained
        foreach (CFG_PLAN[p]) begin
            wait_drained();
            write_classes(CFG_PLAN[p]);
            n = (cfg_now < MIN_CLASSES) ? MIN_CLASSES :
                (cfg_now > CLASSES) ? CLASSES : int'(cfg_now);
            repeat (ITEMS_PER_PHASE)
                push_item(random_item(n));
        end

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Covered %0d records (%0d with a label outside the active classes), %0d reads",
                 record_count, flagged_count, read_count);
        $display("over %0d class settings incl. clamped codes 0, 1, 9, 12 and 15",
                 $size(CFG_PLAN) + 1);
        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
sv/cma_pkg.sv
sv/cma_in_if.sv
sv/cma_out_if.sv
sv/cma_ram.sv
sv/cma_argmax.sv
sv/cma_class_counters.sv
sv/confusion_matrix_accumulator.sv
tb/confusion_checker.sv
tb/tb.sv
